>>> rtl/core/tta_pkg.sv
// Package for the triangle tangent accumulator: widths, commands, controller states, interface structs, helpers.
// No dependencies.
`default_nettype none
package tta_pkg;
	localparam int VERTEX_DEPTH = 1024;
	localparam int IDX_W = $clog2(VERTEX_DEPTH);
	localparam int ACC_W = 48;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_TRI   = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	// Controller states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RD1, ST_RD2, ST_RD3, ST_CAP3,
		ST_DELTA,
		ST_MUL_A, ST_MUL_B,
		ST_DET,
		ST_DIV,
		ST_NUM_A, ST_NUM_B,
		ST_DIR_A, ST_DIR_B, ST_DIR_C, ST_DIR_D,
		ST_ACC_RD, ST_ACC_WAIT, ST_ACC_WR,
		ST_RDV, ST_RDV_WAIT, ST_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic       clr_wr;
		logic       clr_flag;
		logic       load_wr;
		logic       cap_in;
		logic [1:0] vsel;
		logic       vrd;
		logic       vcap;
		logic       delta;
		logic       mul_a;
		logic       mul_b;
		logic       det;
		logic       div_start;
		logic       num_a;
		logic       num_b;
		logic [1:0] dir_step;
		logic       dir_en;
		logic [1:0] csel;
		logic       acc_rd;
		logic       acc_wr;
		logic       rdv;
		logic       out_load;
	} ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic deg;
		logic div_busy;
		logic clr_last;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		if (v > 33'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -33'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W:0] v);
		logic signed [ACC_W:0] mx;
		mx = {2'b00, {(ACC_W-1){1'b1}}};
		if (v > mx) return {1'b0, {(ACC_W-1){1'b1}}};
		if (v < -mx - 1) return {1'b1, {(ACC_W-1){1'b0}}};
		return v[ACC_W-1:0];
	endfunction

	// trunc toward zero of a 64-bit product by 2^16
	function automatic logic signed [47:0] trq16(input logic signed [63:0] p);
		logic signed [63:0] a;
		a = (p < 0) ? p + 64'sd65535 : p;
		return a[63:16];
	endfunction
endpackage
`default_nettype wire

>>> rtl/core/triangle_tangent_accumulator.sv
// Top level of the triangle tangent accumulator.
// Depends on tta_pkg, tta_ctrl, tta_datapath (which holds tta_div).
//
//   channel  dir  handshake                 payload
//   s_axis   in   s_axis_tvalid/tready      tdata: command..tex_v
//   m_axis   out  m_axis_tvalid/tready      tdata: vertex_id..bitangent_z, tuser: degenerate_seen
//
// A load's write lands in the cycle after it is accepted. A read passes through the
// read, wait and output states to its word. A triangle runs the 49-step reciprocal
// divider and the 24 partial-product steps of the direction multiplier; a skipped
// triangle ends after the divider.
// Clear sweeps both memories with no word accepted; after reset the same sweep runs
// before the first word is taken.
// A stalled output holds the result; a following read waits in its output state.
`default_nettype none
module triangle_tangent_accumulator
	import tta_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// command[1:0], first_index[11:2], second_index[21:12], third_index[31:22],
	// pos_x[63:32], pos_y[95:64], pos_z[127:96], tex_u[159:128], tex_v[191:160]
	input  wire logic [191:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// vertex_id[9:0], tangent_x/y/z, bitangent_x/y/z 48 bits each from bit 10, pad
	output logic [303:0]      m_axis_tdata,
	// degenerate_seen
	output logic              m_axis_tuser
);
	ctl_t ctl;
	sts_t sts;
	logic [IDX_W-1:0] oid;
	logic [6*ACC_W-1:0] oacc;

	tta_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cmd(s_axis_tdata[1:0]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.sts(sts), .ctl(ctl)
	);

	tta_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.in_i1(s_axis_tdata[11:2]), .in_i2(s_axis_tdata[21:12]),
		.in_i3(s_axis_tdata[31:22]), .in_vtx(s_axis_tdata[191:32]),
		.out_id(oid), .out_acc(oacc), .out_flag(m_axis_tuser)
	);

	assign m_axis_tdata = {6'd0, oacc, oid};
endmodule
`default_nettype wire

>>> rtl/core/tta_div.sv
// Restoring divider: 2^48 / |det|, one quotient bit per cycle.
// Depends on tta_pkg.
`default_nettype none
module tta_div
	import tta_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [48:0] divisor,
	output logic             busy,
	output logic [48:0]      quot
);
	logic [5:0]  cnt_q;
	logic [49:0] rem_q;
	logic [48:0] quo_q;
	logic [49:0] trial;
	logic        nbit;

	always_comb begin
		nbit  = (cnt_q == 6'd49);
		trial = {rem_q[48:0], nbit} - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy  <= 1'b0;
		end else if (start) begin
			cnt_q <= 6'd49;
			busy  <= 1'b1;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy <= 1'b0;
		end
	end

	// one bit per step: dividend is 1 followed by 48 zeros
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy) begin
			if (!trial[49]) rem_q <= trial;
			else rem_q <= {rem_q[48:0], nbit};
			quo_q <= {quo_q[47:0], ~trial[49]};
		end
	end

	assign quot = quo_q;
endmodule
`default_nettype wire

>>> rtl/core/tta_datapath.sv
// Datapath: vertex and accumulator memories, products, a direction multiplier shared by the six outputs, divider.
// Depends on tta_pkg and tta_div.
`default_nettype none
module tta_datapath
	import tta_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ctl_t             ctl,
	output sts_t                  sts,
	input  wire logic [IDX_W-1:0] in_i1,
	input  wire logic [IDX_W-1:0] in_i2,
	input  wire logic [IDX_W-1:0] in_i3,
	input  wire logic [159:0]     in_vtx,
	output logic [IDX_W-1:0]      out_id,
	output logic [6*ACC_W-1:0]    out_acc,
	output logic                  out_flag
);
	logic [IDX_W-1:0] i1_q, i2_q, i3_q, clr_q;
	logic [159:0] vtx_q;
	logic [159:0] vmem [VERTEX_DEPTH];
	logic [6*ACC_W-1:0] amem [VERTEX_DEPTH];
	logic [159:0] vrd_q;
	logic [6*ACC_W-1:0] ard_q;
	logic signed [31:0] p1_q[5], p2_q[5], p3_q[5];
	logic signed [31:0] d1_q[5], d2_q[5];
	logic signed [47:0] ma_q[7], mb_q[7];
	logic signed [47:0] det_q, nsd_q[3], ntd_q[3];
	logic signed [ACC_W-1:0] dir_q[6];
	logic flag_q;
	logic [IDX_W-1:0] vaddr, aaddr;
	logic div_busy;
	logic [48:0] quot, dmag;
	logic signed [49:0] r_s;
	logic [1:0] cnt;

	// capture command
	always_ff @(posedge clk) begin
		if (ctl.cap_in) begin
			i1_q  <= in_i1;
			i2_q  <= in_i2;
			i3_q  <= in_i3;
			vtx_q <= in_vtx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			flag_q <= 1'b0;
		end else begin
			if (ctl.clr_wr) clr_q <= clr_q + IDX_W'(1);
			if (ctl.clr_flag) flag_q <= 1'b0;
			else if (ctl.div_start && det_q == 0) flag_q <= 1'b1;
		end
	end
	assign sts.clr_last = (clr_q == IDX_W'(VERTEX_DEPTH - 1));
	assign sts.deg = (det_q == 0);
	assign sts.div_busy = div_busy;

	always_comb begin
		unique case (ctl.vsel)
			2'd0: vaddr = i1_q;
			2'd1: vaddr = i2_q;
			default: vaddr = i3_q;
		endcase
		unique case (ctl.csel)
			2'd0: aaddr = i1_q;
			2'd1: aaddr = i2_q;
			default: aaddr = i3_q;
		endcase
	end

	// vertex store
	always_ff @(posedge clk) begin
		if (ctl.clr_wr) vmem[clr_q] <= '0;
		else if (ctl.load_wr) vmem[i1_q] <= vtx_q;
		if (ctl.vrd) vrd_q <= vmem[vaddr];
	end

	// accumulator store
	always_ff @(posedge clk) begin
		if (ctl.clr_wr) amem[clr_q] <= '0;
		else if (ctl.acc_wr) begin
			for (int k = 0; k < 6; k++)
				amem[aaddr][k*ACC_W +: ACC_W] <= sat48(
					{ard_q[k*ACC_W+ACC_W-1], ard_q[k*ACC_W +: ACC_W]} +
					{dir_q[k][ACC_W-1], dir_q[k]});
		end
		if (ctl.acc_rd) ard_q <= amem[aaddr];
		else if (ctl.rdv) ard_q <= amem[i1_q];
	end

	// corner capture, deltas and products
	always_ff @(posedge clk) begin
		if (ctl.vcap) begin
			for (int k = 0; k < 5; k++) begin
				unique case (ctl.vsel)
					2'd1: p1_q[k] <= vrd_q[k*32 +: 32];
					2'd2: p2_q[k] <= vrd_q[k*32 +: 32];
					default: p3_q[k] <= vrd_q[k*32 +: 32];
				endcase
			end
		end
		if (ctl.delta) begin
			for (int k = 0; k < 5; k++) begin
				d1_q[k] <= sat32({p2_q[k][31], p2_q[k]} - {p1_q[k][31], p1_q[k]});
				d2_q[k] <= sat32({p3_q[k][31], p3_q[k]} - {p1_q[k][31], p1_q[k]});
			end
		end
		// ma products: index 0..2 t2*xyz1, 3..5 s1*xyz2, 6 s1*t2
		if (ctl.mul_a) begin
			for (int k = 0; k < 3; k++) begin
				ma_q[k]   <= trq16(64'(d2_q[4] * d1_q[k]));
				ma_q[k+3] <= trq16(64'(d1_q[3] * d2_q[k]));
			end
			ma_q[6] <= trq16(64'(d1_q[3] * d2_q[4]));
		end
		if (ctl.mul_b) begin
			for (int k = 0; k < 3; k++) begin
				mb_q[k]   <= trq16(64'(d1_q[4] * d2_q[k]));
				mb_q[k+3] <= trq16(64'(d2_q[3] * d1_q[k]));
			end
			mb_q[6] <= trq16(64'(d2_q[3] * d1_q[4]));
		end
		if (ctl.det) det_q <= ma_q[6] - mb_q[6];
		if (ctl.num_a) for (int k = 0; k < 3; k++) nsd_q[k] <= ma_q[k] - mb_q[k];
		if (ctl.num_b) for (int k = 0; k < 3; k++) ntd_q[k] <= ma_q[k+3] - mb_q[k+3];
	end

	assign dmag = det_q[47] ? 49'(-det_q) : 49'(det_q);
	tta_div u_div (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_start),
		.divisor(dmag), .busy(div_busy), .quot(quot)
	);
	assign r_s = det_q[47] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

	// direction: |n|*|r| >> 32 in partial products over four steps
	logic [47:0] an_q;
	logic [48:0] ar_q;
	logic [97:0] acc98_q;
	logic neg_q;
	logic signed [47:0] nsel;
	logic [2:0] dsel_q;
	assign cnt = ctl.dir_step;
	always_comb begin
		unique case (dsel_q)
			3'd0: nsel = nsd_q[0];
			3'd1: nsel = nsd_q[1];
			3'd2: nsel = nsd_q[2];
			3'd3: nsel = ntd_q[0];
			3'd4: nsel = ntd_q[1];
			default: nsel = ntd_q[2];
		endcase
	end
	// magnitudes feed the first partial product directly
	logic [47:0] amag;
	logic [48:0] rmag;
	assign amag = nsel[47] ? 48'(-nsel) : 48'(nsel);
	assign rmag = r_s[49] ? 49'(-r_s) : 49'(r_s);
	logic [97:0] pp;
	always_comb begin
		unique case (cnt)
			2'd0: pp = 98'(amag[23:0] * rmag[24:0]);
			2'd1: pp = 98'(an_q[23:0] * ar_q[48:25]) << 25;
			2'd2: pp = 98'(an_q[47:24] * ar_q[24:0]) << 24;
			default: pp = 98'(an_q[47:24] * ar_q[48:25]) << 49;
		endcase
	end
	logic [97:0] sum98;
	logic [65:0] mag;
	logic signed [ACC_W-1:0] dres;
	always_comb begin
		sum98 = acc98_q + pp;
		mag = sum98[97:32];
		if (neg_q) dres = (mag > 66'h800000000000) ? {1'b1, 47'd0} : ACC_W'(-mag);
		else dres = (mag > 66'h7FFFFFFFFFFF) ? {1'b0, {47{1'b1}}} : ACC_W'(mag);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dsel_q <= '0;
		else if (ctl.num_a) dsel_q <= '0;
		else if (ctl.dir_en && cnt == 2'd3) dsel_q <= dsel_q + 3'd1;
	end
	always_ff @(posedge clk) begin
		if (ctl.dir_en) begin
			if (cnt == 2'd0) begin
				an_q    <= amag;
				ar_q    <= rmag;
				neg_q   <= nsel[47] ^ r_s[49];
				acc98_q <= pp;
			end else begin
				acc98_q <= sum98;
			end
		end else if (ctl.det) acc98_q <= '0;
		if (ctl.dir_en && cnt == 2'd3) dir_q[dsel_q] <= dres;
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_id   <= i1_q;
			out_acc  <= ard_q;
			out_flag <= flag_q;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/tta_ctrl.sv
// Controller state machine: sequences clear, load, triangle and read commands.
// Depends on tta_pkg.
`default_nettype none
module tta_ctrl
	import tta_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] in_cmd,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire sts_t       sts,
	output ctl_t            ctl
);
	state_t st_q, st_d;
	logic [1:0] cnt_q, cnt_d;
	logic [1:0] cmd_q;
	logic [2:0] dirn_q, dirn_d;
	logic ov_q;
	logic acc_in;
	// load write happens the cycle after acceptance
	logic ov_load_q;

	assign acc_in = in_valid && in_ready;
	assign in_ready = (st_q == ST_IDLE);
	assign out_valid = ov_q;

	// next state
	always_comb begin
		st_d = st_q;
		cnt_d = cnt_q;
		dirn_d = dirn_q;
		unique case (st_q)
			ST_IDLE: if (acc_in) begin
				unique case (cmd_t'(in_cmd))
					CMD_CLEAR: st_d = ST_CLEAR;
					CMD_LOAD:  st_d = ST_IDLE;
					CMD_TRI:   st_d = ST_RD1;
					default:   st_d = ST_RDV;
				endcase
			end
			ST_CLEAR: if (sts.clr_last) st_d = ST_IDLE;
			ST_RD1: st_d = ST_RD2;
			ST_RD2: st_d = ST_RD3;
			ST_RD3: st_d = ST_CAP3;
			ST_CAP3: st_d = ST_DELTA;
			ST_DELTA: st_d = ST_MUL_A;
			ST_MUL_A: st_d = ST_MUL_B;
			ST_MUL_B: st_d = ST_DET;
			ST_DET: st_d = ST_DIV;
			ST_DIV: if (!sts.div_busy && cnt_q == 2'd1) st_d = sts.deg ? ST_IDLE : ST_NUM_A;
				else cnt_d = 2'd1;
			ST_NUM_A: begin st_d = ST_NUM_B; cnt_d = '0; dirn_d = '0; end
			ST_NUM_B: st_d = ST_DIR_A;
			ST_DIR_A: begin st_d = ST_DIR_B; cnt_d = 2'd1; end
			ST_DIR_B: begin st_d = ST_DIR_C; cnt_d = 2'd2; end
			ST_DIR_C: begin st_d = ST_DIR_D; cnt_d = 2'd3; end
			ST_DIR_D: begin
				cnt_d = '0;
				dirn_d = dirn_q + 3'd1;
				st_d = (dirn_q == 3'd5) ? ST_ACC_RD : ST_DIR_A;
			end
			ST_ACC_RD: st_d = ST_ACC_WAIT;
			ST_ACC_WAIT: st_d = ST_ACC_WR;
			ST_ACC_WR: begin
				cnt_d = cnt_q + 2'd1;
				st_d = (cnt_q == 2'd2) ? ST_IDLE : ST_ACC_RD;
			end
			ST_RDV: st_d = ST_RDV_WAIT;
			ST_RDV_WAIT: st_d = ST_OUT;
			ST_OUT: if (!ov_q || out_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
		if (st_q == ST_DET) cnt_d = '0;
	end

	// outputs
	always_comb begin
		ctl = '0;
		ctl.cap_in = acc_in;
		ctl.load_wr = (st_q == ST_IDLE) && cmd_q == CMD_LOAD && ov_load_q;
		unique case (st_q)
			ST_CLEAR: begin ctl.clr_wr = 1'b1; ctl.clr_flag = 1'b1; end
			ST_RD1: begin ctl.vsel = 2'd0; ctl.vrd = 1'b1; end
			ST_RD2: begin ctl.vsel = 2'd1; ctl.vrd = 1'b1; ctl.vcap = 1'b1; end
			ST_RD3: begin ctl.vsel = 2'd2; ctl.vrd = 1'b1; ctl.vcap = 1'b1; end
			ST_CAP3: begin ctl.vsel = 2'd3; ctl.vcap = 1'b1; end
			ST_DELTA: ctl.delta = 1'b1;
			ST_MUL_A: ctl.mul_a = 1'b1;
			ST_MUL_B: ctl.mul_b = 1'b1;
			ST_DET: ctl.det = 1'b1;
			ST_DIV: ctl.div_start = (cnt_q == 2'd0);
			ST_NUM_A: ctl.num_a = 1'b1;
			ST_NUM_B: ctl.num_b = 1'b1;
			ST_DIR_A, ST_DIR_B, ST_DIR_C, ST_DIR_D: begin
				ctl.dir_en = 1'b1;
				ctl.dir_step = cnt_q;
			end
			ST_ACC_RD: begin ctl.csel = cnt_q; ctl.acc_rd = 1'b1; end
			ST_ACC_WAIT: ctl.csel = cnt_q;
			ST_ACC_WR: begin ctl.csel = cnt_q; ctl.acc_wr = 1'b1; end
			ST_RDV: ctl.rdv = 1'b1;
			ST_OUT: ctl.out_load = (!ov_q || out_ready);
			default: ;
		endcase
	end

	// state registers; reset starts with a sweep of both memories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			cnt_q <= '0;
			dirn_q <= '0;
			cmd_q <= '0;
			ov_q <= 1'b0;
			ov_load_q <= 1'b0;
		end else begin
			st_q <= st_d;
			cnt_q <= cnt_d;
			dirn_q <= dirn_d;
			if (acc_in) cmd_q <= in_cmd;
			ov_load_q <= acc_in && in_cmd == CMD_LOAD;
			if (ctl.out_load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/tta_checker.sv
// Port checker for the triangle tangent accumulator, bound to the top level.
// Depends on tta_pkg.
`default_nettype none
module tta_checker
	import tta_pkg::*;
(
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic [191:0] s_axis_tdata,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [303:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != CMD_LOAD |=> !s_axis_tready)
		else $error("accepted word while busy");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !$isunknown(m_axis_tdata))
		else $error("unknown bits in result");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[303:298] == 6'd0)
		else $error("pad bits set");
endmodule

bind triangle_tangent_accumulator tta_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.s_axis_tdata(s_axis_tdata),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

>>> tb/tb_tta_checker.sv
// Checker for the triangle tangent accumulator: watches both stream channels,
// predicts read words from its own vertex and sum stores, compares field by field.
// Depends on tta_pkg.
`timescale 1ns / 100ps
module tb_tta_checker
	import tta_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic         in_ready,
	input  wire logic [191:0] in_data,
	input  wire logic         out_valid,
	input  wire logic         out_ready,
	input  wire logic [303:0] out_data,
	input  wire logic         out_flag,
	output int                fail_count,
	output int                pending
);
	typedef struct packed {
		logic [9:0]        vid;
		logic [5:0][47:0]  sums;
		logic              deg;
	} read_word_t;

	localparam longint ACC_MAX = 64'sh00007FFFFFFFFFFF;
	localparam longint ACC_MIN = -ACC_MAX - 1;

	int     vx [VERTEX_DEPTH], vy [VERTEX_DEPTH], vz [VERTEX_DEPTH];
	int     vu [VERTEX_DEPTH], vv [VERTEX_DEPTH];
	longint sum_tan [VERTEX_DEPTH][3];
	longint sum_bit [VERTEX_DEPTH][3];
	bit     deg_flag;
	read_word_t read_q[$];

	assign pending = read_q.size();

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint clip48(longint v);
		if (v > ACC_MAX) return ACC_MAX;
		if (v < ACC_MIN) return ACC_MIN;
		return v;
	endfunction

	// a*b/2^16 - c*d/2^16, each quotient truncated toward zero
	function automatic longint cross_q16(longint a, longint b, longint c, longint d);
		return (a * b) / 65536 - (c * d) / 65536;
	endfunction

	// trunc(n*r/2^32) in wide arithmetic, then clipped to 48 bits
	function automatic longint scale_dir(longint n, longint r);
		logic signed [127:0] p;
		p = 128'(signed'(n)) * 128'(signed'(r));
		if (p < 0) p = -((-p) >>> 32);
		else p = p >>> 32;
		if (p > 128'(ACC_MAX)) return ACC_MAX;
		if (p < -128'(ACC_MAX) - 1) return ACC_MIN;
		return longint'(p);
	endfunction

	task automatic wipe_all();
		for (int i = 0; i < VERTEX_DEPTH; i++) begin
			vx[i] = 0; vy[i] = 0; vz[i] = 0; vu[i] = 0; vv[i] = 0;
			for (int k = 0; k < 3; k++) begin
				sum_tan[i][k] = 0;
				sum_bit[i][k] = 0;
			end
		end
		deg_flag = 0;
	endtask

	task automatic accumulate_triangle(int c[3]);
		longint x1, x2, y1, y2, z1, z2, s1, s2, t1, t2, det, r, mag;
		longint sd[3], td[3];
		x1 = clip32(longint'(vx[c[1]]) - vx[c[0]]);
		x2 = clip32(longint'(vx[c[2]]) - vx[c[0]]);
		y1 = clip32(longint'(vy[c[1]]) - vy[c[0]]);
		y2 = clip32(longint'(vy[c[2]]) - vy[c[0]]);
		z1 = clip32(longint'(vz[c[1]]) - vz[c[0]]);
		z2 = clip32(longint'(vz[c[2]]) - vz[c[0]]);
		s1 = clip32(longint'(vu[c[1]]) - vu[c[0]]);
		s2 = clip32(longint'(vu[c[2]]) - vu[c[0]]);
		t1 = clip32(longint'(vv[c[1]]) - vv[c[0]]);
		t2 = clip32(longint'(vv[c[2]]) - vv[c[0]]);
		det = cross_q16(s1, t2, s2, t1);
		if (det == 0) begin
			deg_flag = 1;
			return;
		end
		mag = det < 0 ? -det : det;
		r = (64'sd1 <<< 48) / mag;
		if (det < 0) r = -r;
		sd[0] = scale_dir(cross_q16(t2, x1, t1, x2), r);
		sd[1] = scale_dir(cross_q16(t2, y1, t1, y2), r);
		sd[2] = scale_dir(cross_q16(t2, z1, t1, z2), r);
		td[0] = scale_dir(cross_q16(s1, x2, s2, x1), r);
		td[1] = scale_dir(cross_q16(s1, y2, s2, y1), r);
		td[2] = scale_dir(cross_q16(s1, z2, s2, z1), r);
		for (int j = 0; j < 3; j++)
			for (int k = 0; k < 3; k++) begin
				sum_tan[c[j]][k] = clip48(sum_tan[c[j]][k] + sd[k]);
				sum_bit[c[j]][k] = clip48(sum_bit[c[j]][k] + td[k]);
			end
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		fail_count++;
		$display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
	endtask

	initial begin
		fail_count = 0;
		wipe_all();
	end

	// input side: update the model on each accepted word
	always @(posedge clk) begin
		int c[3];
		read_word_t w;
		if (arst_n && in_valid && in_ready) begin
			c[0] = in_data[11:2];
			c[1] = in_data[21:12];
			c[2] = in_data[31:22];
			case (cmd_t'(in_data[1:0]))
				CMD_CLEAR: wipe_all();
				CMD_LOAD: begin
					vx[c[0]] = in_data[63:32];
					vy[c[0]] = in_data[95:64];
					vz[c[0]] = in_data[127:96];
					vu[c[0]] = in_data[159:128];
					vv[c[0]] = in_data[191:160];
				end
				CMD_TRI: accumulate_triangle(c);
				CMD_READ: begin
					w.vid = c[0];
					for (int k = 0; k < 3; k++) begin
						w.sums[k] = sum_tan[c[0]][k][47:0];
						w.sums[k+3] = sum_bit[c[0]][k][47:0];
					end
					w.deg = deg_flag;
					read_q.insert(read_q.size(), w);
				end
			endcase
		end
	end

	// output side: compare against the oldest read
	always @(posedge clk) begin
		read_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (read_q.size() == 0) begin
				report("unexpected word", out_data[63:0], 0);
			end else begin
				w = read_q.pop_front();
				if (out_data[9:0] != w.vid) report("vertex_id", out_data[9:0], w.vid);
				for (int k = 0; k < 6; k++)
					if (out_data[10+48*k +: 48] != w.sums[k])
						report($sformatf("sum %0d of vertex %0d", k, w.vid),
							out_data[10+48*k +: 48], w.sums[k]);
				if (out_flag != w.deg) report("degenerate_seen", out_flag, w.deg);
			end
		end
	end
endmodule

>>> tb/tb.sv
// Testbench top for the triangle tangent accumulator: clock, reset, stimulus
// and verdict. Depends on tta_pkg, the block and tb_tta_checker.
`timescale 1ns / 100ps
module tb;
	import tta_pkg::*;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [303:0] m_axis_tdata;
	logic         m_axis_tuser;
	int           fail_count, pending;
	int           send_idle_pct = 0, recv_stall_pct = 0;
	bit           hold_off = 0;
	longint       cycles = 0;
	bit           loaded [VERTEX_DEPTH];
	int           loaded_list[$];

	localparam longint CYCLE_LIMIT = 3000000;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	triangle_tangent_accumulator u_dut (.*);

	tb_tta_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(m_axis_tdata), .out_flag(m_axis_tuser),
		.fail_count(fail_count), .pending(pending)
	);

	// receiver stalls
	always @(posedge clk)
		m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [191:0] pack_word(cmd_t cmd, logic [9:0] a, logic [9:0] b,
			logic [9:0] c, logic [4:0][31:0] vals);
		return {vals, c, b, a, cmd};
	endfunction

	task automatic send(logic [191:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= w;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic go_idle();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom;
			default: return 32'($signed($urandom_range(2 ** 21)) - 2 ** 20);
		endcase
	endfunction

	task automatic load_vertex(int i, logic [4:0][31:0] vals);
		send(pack_word(CMD_LOAD, i, $urandom, $urandom, vals));
		if (!loaded[i]) loaded_list.insert(loaded_list.size(), i);
		loaded[i] = 1;
	endtask

	task automatic do_clear();
		send(pack_word(CMD_CLEAR, $urandom, $urandom, $urandom, {$urandom, $urandom,
			$urandom, $urandom, $urandom}));
		for (int i = 0; i < VERTEX_DEPTH; i++) loaded[i] = 1;
		loaded_list.delete();
		for (int i = 0; i < VERTEX_DEPTH; i++) loaded_list.insert(loaded_list.size(), i);
	endtask

	function automatic int pick_loaded();
		return loaded_list[$urandom_range(loaded_list.size() - 1)];
	endfunction

	task automatic send_read(int i);
		send(pack_word(CMD_READ, i, $urandom, $urandom, {$urandom, $urandom,
			$urandom, $urandom, $urandom}));
	endtask

	task automatic send_tri(int a, int b, int c);
		send(pack_word(CMD_TRI, a, b, c, {$urandom, $urandom, $urandom, $urandom,
			$urandom}));
	endtask

	// random traffic: mostly small meshes, a random mix of loads, triangles, reads and rare clears
	task automatic random_phase(int n);
		int a, b, c;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4: begin
					a = $urandom_range(3) == 0 ? $urandom_range(1023) : $urandom_range(15);
					load_vertex(a, {rand_coord(), rand_coord(), rand_coord(),
						rand_coord(), rand_coord()});
				end
				5, 6, 7, 8, 9, 10: begin
					a = pick_loaded(); b = pick_loaded(); c = pick_loaded();
					send_tri(a, b, c);
				end
				19: if ($urandom_range(9) == 0) do_clear();
				default: send_read($urandom_range(3) == 0 ? $urandom_range(1023) : pick_loaded());
			endcase
		end
	endtask

	initial begin
		for (int i = 0; i < VERTEX_DEPTH; i++) loaded[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: clean mesh, extremes, degenerate, repeated corners
		load_vertex(0, {32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0});
		load_vertex(1, {32'h0, 32'h00010000, 32'h0, 32'h0, 32'h00010000});
		load_vertex(2, {32'h00010000, 32'h0, 32'h0, 32'h00010000, 32'h0});
		load_vertex(1023, {32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF});
		load_vertex(3, {32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000});
		send_tri(0, 1, 2);
		send_tri(0, 0, 1);
		send_tri(1023, 3, 0);
		send_tri(3, 1023, 2);
		send_tri(1023, 1023, 1023);
		load_vertex(4, {32'h00000001, 32'hFFFFFFFF, 32'h0, 32'h00000001, 32'h00000000});
		send_tri(0, 4, 2);
		send_tri(2, 1, 0);
		send_read(0); send_read(1); send_read(2); send_read(3);
		send_read(1023); send_read(4); send_read(500);
		go_idle();
		do_clear();
		send_read(0); send_read(1023);
		go_idle();

		// extremes of accumulation: same triangle repeatedly
		load_vertex(5, {32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
		load_vertex(6, {32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'h0});
		load_vertex(7, {32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h00000001});
		repeat (6) send_tri(5, 6, 7);
		send_read(5); send_read(6);

		// phases of idling
		random_phase(400);
		send_idle_pct = 66;
		random_phase(400);
		send_idle_pct = 0; recv_stall_pct = 66;
		random_phase(400);

		// receiver holds off while reads keep coming
		fork
			begin
				hold_off = 1;
				repeat (3000) @(posedge clk);
				hold_off = 0;
			end
			for (int k = 0; k < 30; k++) send_read(pick_loaded());
		join
		go_idle();
		send_idle_pct = 25; recv_stall_pct = 25;
		random_phase(400);
		send_idle_pct = 0; recv_stall_pct = 0;
		random_phase(300);

		go_idle();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

>>> files.f
rtl/core/tta_pkg.sv
rtl/core/tta_div.sv
rtl/core/tta_datapath.sv
rtl/core/tta_ctrl.sv
rtl/core/triangle_tangent_accumulator.sv
rtl/core/tta_checker.sv
tb/tb_tta_checker.sv
tb/tb.sv
